@@ rtl/core/adc_rrs_pkg.sv @@
// Shared types, constants and helpers for the ADC round-robin scanner.
`timescale 1ns / 1ps
`default_nettype none

package adc_rrs_pkg;

   localparam int MAX_CHANNELS  = 8;
   localparam int MUX_BITS      = 5;
   localparam int MUX_CODES     = 1 << MUX_BITS;
   localparam int SAMPLE_BITS   = 10;
   localparam int COUNT_BITS    = 4;
   localparam int POS_BITS      = 3;
   localparam int LIST_BITS     = MAX_CHANNELS * MUX_BITS;
   localparam int CSR_DATA_BITS = LIST_BITS;
   localparam int CSR_IDX_BITS  = 1;

   typedef enum logic {
      OP_READ = 1'b0,
      OP_CONV = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_COUNT = 1'b0,
      CSR_LIST  = 1'b1
   } csr_idx_type;

   typedef struct packed {
      op_type                 operation;
      logic [MUX_BITS-1:0]    channel;
      logic [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] read_value;
      logic                   start_conversion;
      logic [MUX_BITS-1:0]    current_mux;
   } rsp_type;

   // Access to the value store issued by the sequencer.
   typedef struct packed {
      logic                   we;
      logic                   re;
      logic [MUX_BITS-1:0]    addr;
      logic [SAMPLE_BITS-1:0] wdata;
   } store_cmd_type;

   // Registered response control from the sequencer.
   typedef struct packed {
      logic                valid;
      logic                read_op;
      logic                start;
      logic [MUX_BITS-1:0] mux;
   } seq_rsp_type;

   function automatic logic [MUX_BITS-1:0] list_entry(input logic [LIST_BITS-1:0] list,
                                                      input logic [POS_BITS-1:0]  pos);
      list_entry = list[pos*MUX_BITS +: MUX_BITS];
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/adc_rrs_store.sv @@
// Value store: synchronous sample memory with per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module adc_rrs_store (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire adc_rrs_pkg::store_cmd_type            cmd,
   output      logic [adc_rrs_pkg::SAMPLE_BITS-1:0]   rdata
);

   logic [adc_rrs_pkg::SAMPLE_BITS-1:0] mem [adc_rrs_pkg::MUX_CODES];
   logic [adc_rrs_pkg::MUX_CODES-1:0]   valid_ff;
   logic [adc_rrs_pkg::SAMPLE_BITS-1:0] rdata_ff;
   logic                                hit_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      if (cmd.re) begin
         rdata_ff <= mem[cmd.addr];
      end
   end

   // Entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (cmd.we) begin
            valid_ff[cmd.addr] <= 1'b1;
         end
         if (cmd.re) begin
            hit_ff <= valid_ff[cmd.addr];
         end
      end
   end

   assign rdata = hit_ff ? rdata_ff : '0;

endmodule

`default_nettype wire

@@ rtl/core/adc_rrs_seq.sv @@
// Scan sequencer: configuration, list position, mux selection and conversion flag.
`timescale 1ns / 1ps
`default_nettype none

module adc_rrs_seq (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    accept,
   input  wire adc_rrs_pkg::req_type                    req,
   input  wire logic                                    csr_we,
   input  wire logic [adc_rrs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [adc_rrs_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output      adc_rrs_pkg::store_cmd_type              cmd,
   output      adc_rrs_pkg::seq_rsp_type                rsp_ctl
);

   logic [adc_rrs_pkg::COUNT_BITS-1:0] count_ff;
   logic [adc_rrs_pkg::LIST_BITS-1:0]  list_ff;
   logic [adc_rrs_pkg::POS_BITS-1:0]   pos_ff;
   logic [adc_rrs_pkg::MUX_BITS-1:0]   sel_ff;
   logic                               converting_ff;
   adc_rrs_pkg::seq_rsp_type           rsp_ff;

   logic [adc_rrs_pkg::COUNT_BITS-1:0] count_eff;
   logic [adc_rrs_pkg::COUNT_BITS-1:0] next_wide;
   logic [adc_rrs_pkg::POS_BITS-1:0]   next_pos;
   logic [adc_rrs_pkg::MUX_BITS-1:0]   next_mux;
   logic                               is_conv;

   always_comb begin
      if (count_ff == '0) begin
         count_eff = adc_rrs_pkg::COUNT_BITS'(1);
      end else if (count_ff > adc_rrs_pkg::COUNT_BITS'(adc_rrs_pkg::MAX_CHANNELS)) begin
         count_eff = adc_rrs_pkg::COUNT_BITS'(adc_rrs_pkg::MAX_CHANNELS);
      end else begin
         count_eff = count_ff;
      end
      next_wide = adc_rrs_pkg::COUNT_BITS'(pos_ff) + adc_rrs_pkg::COUNT_BITS'(1);
      // Wrap right after the last configured entry.
      next_pos  = (next_wide >= count_eff) ? '0 : next_wide[adc_rrs_pkg::POS_BITS-1:0];
      next_mux  = adc_rrs_pkg::list_entry(list_ff, next_pos);
   end

   assign is_conv = (req.operation == adc_rrs_pkg::OP_CONV);

   always_comb begin
      cmd.we    = accept && is_conv;
      cmd.re    = accept && !is_conv;
      cmd.addr  = is_conv ? sel_ff : req.channel;
      cmd.wdata = req.sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= adc_rrs_pkg::COUNT_BITS'(1);
         list_ff       <= '0;
         pos_ff        <= '0;
         sel_ff        <= '0;
         converting_ff <= 1'b1;
         rsp_ff        <= '0;
      end else begin
         rsp_ff.valid <= accept;
         if (accept) begin
            rsp_ff.read_op <= !is_conv;
            if (is_conv) begin
               converting_ff <= 1'b0;
               pos_ff        <= next_pos;
               sel_ff        <= next_mux;
               rsp_ff.start  <= 1'b0;
               rsp_ff.mux    <= next_mux;
            end else begin
               converting_ff <= 1'b1;
               rsp_ff.start  <= !converting_ff;
               rsp_ff.mux    <= sel_ff;
            end
         end
         // Restart the scan on any register write.
         if (csr_we) begin
            unique case (csr_index)
               adc_rrs_pkg::CSR_COUNT: begin
                  count_ff <= csr_wdata[adc_rrs_pkg::COUNT_BITS-1:0];
                  pos_ff   <= '0;
                  sel_ff   <= adc_rrs_pkg::list_entry(list_ff, '0);
               end
               adc_rrs_pkg::CSR_LIST: begin
                  list_ff <= csr_wdata[adc_rrs_pkg::LIST_BITS-1:0];
                  pos_ff  <= '0;
                  sel_ff  <= csr_wdata[adc_rrs_pkg::MUX_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_ctl = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/core/adc_round_robin_scanner_unit.sv @@
// Top level of the ADC round-robin channel scanner.
// Response: rsp_valid is registered and comes in the cycle after the request is accepted.
// Throughput: one item per cycle; busy stays low, and the value store read and
// write are never issued together, so they never collide.
// Reset: synchronous; value store reads zero, scan at entry zero, conversion running.
// The receiver cannot stall: each beat is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module adc_round_robin_scanner_unit (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output      logic                                    busy,
   input  wire adc_rrs_pkg::req_type                    req_item,
   output      logic                                    rsp_valid,
   output      adc_rrs_pkg::rsp_type                    rsp_item,
   input  wire logic                                    csr_we,
   input  wire logic [adc_rrs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [adc_rrs_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   adc_rrs_pkg::store_cmd_type          cmd;
   adc_rrs_pkg::seq_rsp_type            rsp_ctl;
   logic [adc_rrs_pkg::SAMPLE_BITS-1:0] rdata;
   logic                                accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   adc_rrs_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .rsp_ctl   (rsp_ctl)
   );

   adc_rrs_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rdata (rdata)
   );

   assign rsp_valid = rsp_ctl.valid;

   // Drop the stored value on conversion beats.
   always_comb begin
      rsp_item.read_value       = rsp_ctl.read_op ? rdata : '0;
      rsp_item.start_conversion = rsp_ctl.start;
      rsp_item.current_mux      = rsp_ctl.mux;
   end

endmodule

`default_nettype wire

@@ bench/adc_rrs_scan_checker.sv @@
// Checker that predicts every scanner response and compares it with the one observed.
`timescale 1ns / 1ps

module adc_rrs_scan_checker
   import adc_rrs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  req_type                  req_item,
   input  logic                     rsp_valid,
   input  rsp_type                  rsp_item,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       fail_count,
   output int                       outstanding
);

   logic [SAMPLE_BITS-1:0] stored_sample [MUX_CODES];
   logic [POS_BITS-1:0]    scan_pos;
   logic [MUX_BITS-1:0]    scan_mux;
   logic                   conv_running;
   logic [COUNT_BITS-1:0]  scan_count;
   logic [LIST_BITS-1:0]   scan_list;
   rsp_type                due_rsp [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic logic [MUX_BITS-1:0] mux_at(input logic [POS_BITS-1:0] pos);
      logic [LIST_BITS-1:0] shifted;
      shifted = scan_list >> (int'(pos) * MUX_BITS);
      return shifted[MUX_BITS-1:0];
   endfunction

   // Zero counts as one entry; anything above the list length saturates.
   function automatic int active_entries();
      if (scan_count == 0) return 1;
      if (scan_count > MAX_CHANNELS) return MAX_CHANNELS;
      return int'(scan_count);
   endfunction

   function automatic rsp_type scan_step(input req_type beat);
      rsp_type r;
      int      nxt;
      r = '0;
      if (beat.operation == OP_CONV) begin
         stored_sample[scan_mux] = beat.sample;
         conv_running = 1'b0;
         nxt = int'(scan_pos) + 1;
         if (nxt >= active_entries()) nxt = 0;
         scan_pos = nxt[POS_BITS-1:0];
         scan_mux = mux_at(scan_pos);
      end else begin
         // A read kicks off a conversion only when the converter is idle.
         if (!conv_running) begin
            conv_running = 1'b1;
            r.start_conversion = 1'b1;
         end
         r.read_value = stored_sample[beat.channel];
      end
      r.current_mux = scan_mux;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < MUX_CODES; i++) stored_sample[i] = '0;
         scan_count   = COUNT_BITS'(1);
         scan_list    = '0;
         scan_pos     = '0;
         scan_mux     = mux_at('0);
         conv_running = 1'b1;
         due_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (due_rsp.size() == 0) begin
               $error("unexpected response beat: %p", rsp_item);
               fail_count++;
            end else begin
               want = due_rsp.pop_front();
               if (rsp_item.read_value !== want.read_value) begin
                  $error("read_value expected %0d got %0d",
                         want.read_value, rsp_item.read_value);
                  fail_count++;
               end
               if (rsp_item.start_conversion !== want.start_conversion) begin
                  $error("start_conversion expected %0d got %0d",
                         want.start_conversion, rsp_item.start_conversion);
                  fail_count++;
               end
               if (rsp_item.current_mux !== want.current_mux) begin
                  $error("current_mux expected %0d got %0d",
                         want.current_mux, rsp_item.current_mux);
                  fail_count++;
               end
            end
         end
         // Any register write restarts the scan at entry zero.
         if (csr_we) begin
            if (csr_index == CSR_COUNT) scan_count = csr_wdata[COUNT_BITS-1:0];
            else scan_list = csr_wdata;
            scan_pos = '0;
            scan_mux = mux_at('0);
         end
         if (start && !busy) due_rsp.push_back(scan_step(req_item));
      end
      outstanding <= due_rsp.size();
   end

endmodule

@@ bench/adc_round_robin_scanner_unit_tb.sv @@
// Testbench top: drives scan requests and register writes, reports the verdict.
`timescale 1ns / 1ps

module adc_round_robin_scanner_unit_tb;
   import adc_rrs_pkg::*;

   localparam int CYCLE_LIMIT   = 100000;
   localparam int PHASE_ITEMS   = 155;
   localparam int RANDOM_PHASES = 10;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     start     = 1'b0;
   logic                     busy;
   req_type                  req_item  = '0;
   logic                     rsp_valid;
   rsp_type                  rsp_item;
   logic                     csr_we    = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int                       fail_count;
   int                       outstanding;
   int                       cycle_count = 0;
   bit                       idle_on     = 1'b0;
   logic [COUNT_BITS-1:0]    cur_count   = COUNT_BITS'(1);
   logic [LIST_BITS-1:0]     cur_list    = '0;

   always #1 clock = ~clock;

   adc_round_robin_scanner_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   adc_rrs_scan_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic req_type mk(input op_type op, input int ch, input int smp);
      req_type r;
      r.operation = op;
      r.channel   = ch[MUX_BITS-1:0];
      r.sample    = smp[SAMPLE_BITS-1:0];
      return r;
   endfunction

   // Hold start high until the beat is taken; optionally idle first.
   task automatic push_item(input req_type item);
      while (idle_on && $urandom_range(0, 99) < 18) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_config(input logic [COUNT_BITS-1:0] count,
                               input logic [LIST_BITS-1:0] list, input bit with_list);
      csr_we    <= 1'b1;
      csr_index <= CSR_COUNT;
      csr_wdata <= CSR_DATA_BITS'(count);
      @(posedge clock);
      if (with_list) begin
         csr_index <= CSR_LIST;
         csr_wdata <= list;
         @(posedge clock);
         cur_list = list;
      end
      csr_we    <= 1'b0;
      cur_count = count;
   endtask

   initial begin
      int                    counts [RANDOM_PHASES];
      int                    active;
      int                    ch;
      logic [LIST_BITS-1:0]  list;
      logic [LIST_BITS-1:0]  shifted;

      counts = '{8, 1, 0, 15, 3, 9, 8, 2, 6, 12};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset state: conversion running, single entry at mux zero.
      push_item(mk(OP_READ, 0, 0));
      push_item(mk(OP_READ, 31, 1023));
      push_item(mk(OP_CONV, 31, 1023));
      push_item(mk(OP_READ, 0, 0));
      push_item(mk(OP_READ, 0, 0));
      push_item(mk(OP_CONV, 0, 0));
      push_item(mk(OP_CONV, 5, 682));
      push_item(mk(OP_READ, 0, 341));
      drain();

      // Full list with distinct codes; nine conversions wrap past the last entry.
      write_config(8, {5'd21, 5'd0, 5'd16, 5'd8, 5'd4, 5'd2, 5'd1, 5'd31}, 1'b1);
      for (int i = 0; i < 9; i++) push_item(mk(OP_CONV, i, 1023 - i * 100));
      push_item(mk(OP_READ, 31, 0));
      push_item(mk(OP_READ, 21, 1023));
      push_item(mk(OP_READ, 16, 0));

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         if (ph == 1) list = '1;
         else if (ph == 2) list = '0;
         else list = LIST_BITS'({$urandom, $urandom});
         write_config(counts[ph][COUNT_BITS-1:0], list, ph != 5);
         idle_on = (ph != 3);
         active = (cur_count == 0) ? 1 : (cur_count > MAX_CHANNELS) ? MAX_CHANNELS
                                                                   : int'(cur_count);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Favor reads of codes on the scan list so stored samples come back.
            if ($urandom_range(0, 9) < 6) begin
               shifted = cur_list >> ($urandom_range(0, active - 1) * MUX_BITS);
               ch = int'(shifted[MUX_BITS-1:0]);
            end else begin
               ch = $urandom_range(0, MUX_CODES - 1);
            end
            push_item(mk($urandom_range(0, 1) ? OP_CONV : OP_READ, ch,
                         $urandom_range(0, (1 << SAMPLE_BITS) - 1)));
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
